>>> rtl/brs_pkg.sv
package brs_pkg;

  localparam int DATA_W = 32;
  localparam int RANK_W = 9;

  localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] INT_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_DOWN   = 2'd2,
    CMD_UP     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

>>> rtl/brs_in_if.sv
interface brs_in_if;
  import brs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               cmd;
  logic signed [DATA_W-1:0] value;
  logic signed [DATA_W-1:0] bound;
  logic [RANK_W-1:0]        rank;

  modport source (output valid, output cmd, output value, output bound, output rank,
                  input ready);
  modport sink (input valid, input cmd, input value, input bound, input rank,
                output ready);
endinterface

>>> rtl/brs_out_if.sv
interface brs_out_if;
  import brs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] answer;

  modport source (output valid, output answer, input ready);
  modport sink (input valid, input answer, output ready);
endinterface

>>> rtl/brs_ram.sv
module brs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/bounded_rank_select_top.sv
// Rank selection over a store of up to DEPTH signed 32-bit values.
//
// in_ch carries one item per handshake: cmd selects clear, append, downward
// query or upward query; value is used by append, bound and rank by queries.
// out_ch carries one answer per query item; clear and append give none.
//
// Clear and append need no scan. A query walks rank-1 steps; each step
// reads every stored value once through the single RAM read port and one
// shared compare unit. A query whose rank reaches the count does one
// min/max sweep instead. in_ch.ready is high only while no query is in
// progress.
//
// The answer sits in an output register; a new item is taken while it waits.
// If the receiver stalls, a finished query holds in its final state until
// the output register frees up. Synchronous active-low reset empties the
// store (count to zero) and drops any pending answer; RAM contents are not
// cleared since only entries below the count are ever read.
module bounded_rank_select_top #(
  parameter int DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  brs_in_if.sink           in_ch,
  brs_out_if.source        out_ch
);
  import brs_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = (CW > RANK_W) ? CW : RANK_W;

  state_t state_r, state_nxt;

  logic [CW-1:0]             count_r, count_nxt;
  logic [CW-1:0]             idx_r, idx_nxt;
  logic [RANK_W-1:0]         steps_r, steps_nxt;
  logic                      down_r, down_nxt;     // downward query
  logic                      ext_r, ext_nxt;       // plain min/max sweep
  logic signed [DATA_W-1:0]  best_r, best_nxt;
  logic signed [DATA_W-1:0]  bound_r, bound_nxt;   // also holds final answer
  logic                      rd_vld_r, rd_vld_nxt;
  logic                      rd_last_r, rd_last_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0]  answer_r, answer_nxt;

  logic                      accept;
  logic                      full;
  logic                      we;
  logic [DATA_W-1:0]         rdata;
  logic signed [DATA_W-1:0]  rd_val;
  logic                      take;
  logic signed [DATA_W-1:0]  best_new;
  logic signed [DATA_W-1:0]  init_val;
  logic                      q_down;
  logic                      q_ext;
  logic [CW-1:0]             idx_inc;

  // new items only between queries
  assign in_ch.ready = (state_r == ST_IDLE);

  assign accept  = in_ch.valid && in_ch.ready;
  assign full    = (count_r == CW'(DEPTH));
  assign we      = accept && (cmd_t'(in_ch.cmd) == CMD_APPEND) && !full;
  assign rd_val  = $signed(rdata);
  assign idx_inc = idx_r + CW'(1);

  brs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (count_r[AW-1:0]),
    .wdata (in_ch.value),
    .raddr (idx_r[AW-1:0]),
    .rdata (rdata)
  );

  // shared compare unit: one candidate against running best and, outside a min/max sweep, the bound
  always_comb begin
    if (ext_r) begin
      take = down_r ? (rd_val < best_r) : (rd_val > best_r);
    end else if (down_r) begin
      take = (rd_val > best_r) && (rd_val < bound_r);
    end else begin
      take = (rd_val < best_r) && (rd_val > bound_r);
    end
    best_new = take ? rd_val : best_r;
  end

  // query setup decode
  assign q_down   = (cmd_t'(in_ch.cmd) == CMD_DOWN);
  assign q_ext    = (MW'(in_ch.rank) >= MW'(count_r));
  assign init_val = (q_down ^ q_ext) ? INT_MIN : INT_MAX;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    steps_nxt     = steps_r;
    down_nxt      = down_r;
    ext_nxt       = ext_r;
    best_nxt      = best_r;
    bound_nxt     = bound_r;
    rd_vld_nxt    = 1'b0;
    rd_last_nxt   = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    answer_nxt    = answer_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_t'(in_ch.cmd))
            CMD_CLEAR: begin
              count_nxt = '0;
            end
            CMD_APPEND: begin
              if (!full) begin
                count_nxt = count_r + CW'(1);
              end
            end
            default: begin
              down_nxt  = q_down;
              ext_nxt   = q_ext;
              best_nxt  = init_val;
              idx_nxt   = '0;
              steps_nxt = in_ch.rank - RANK_W'(1);
              if (q_ext) begin
                bound_nxt = init_val;
                state_nxt = (count_r == '0) ? ST_FINISH : ST_SCAN;
              end else begin
                bound_nxt = in_ch.bound;
                state_nxt = (in_ch.rank <= RANK_W'(1)) ? ST_FINISH : ST_SCAN;
              end
            end
          endcase
        end
      end

      ST_SCAN: begin
        // issue one read per cycle while idx is below the count; data returns through the registered RAM read
        if (idx_r < count_r) begin
          idx_nxt     = idx_inc;
          rd_vld_nxt  = 1'b1;
          rd_last_nxt = (idx_inc == count_r);
        end
        if (rd_vld_r) begin
          best_nxt = best_new;
          if (rd_last_r) begin
            // end of a sweep: result becomes the next bound
            bound_nxt = best_new;
            best_nxt  = down_r ? INT_MIN : INT_MAX;
            idx_nxt   = '0;
            if (ext_r || steps_r == RANK_W'(1)) begin
              state_nxt = ST_FINISH;
            end else begin
              steps_nxt = steps_r - RANK_W'(1);
            end
          end
        end
      end

      ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          answer_nxt    = bound_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      rd_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      rd_last_r   <= rd_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    steps_r  <= steps_nxt;
    down_r   <= down_nxt;
    ext_r    <= ext_nxt;
    best_r   <= best_nxt;
    bound_r  <= bound_nxt;
    answer_r <= answer_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.answer = answer_r;

endmodule

>>> test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import brs_pkg::*;

  localparam int STORE_DEPTH = 256;
  // Minimum random items per handshake phase.
  localparam int PHASE_ITEMS = 15;
  localparam int N_PHASES = 4;
  localparam int N_ROWS = 25;

  // One row of the directed table. A row with has_answer set carries an
  // answer that is obvious by inspection; all other queries go through
  // select_answer.
  typedef struct packed {
    cmd_t                     cmd;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] bound;
    logic [RANK_W-1:0]        rank;
    logic                     has_answer;
    logic signed [DATA_W-1:0] answer;
  } row_t;

  // Directed store after the six appends: INT_MIN, INT_MAX, 0, -7, 100, 100.
  localparam row_t DIRECTED [N_ROWS] = '{
    // empty store: any query is a plain min/max query and returns the sweep seed
    '{CMD_DOWN,   32'sd0,        32'sd5,        9'd0,   1'b1, INT_MAX},
    '{CMD_UP,     32'sd0,        32'sd5,        9'd3,   1'b1, INT_MIN},
    '{CMD_APPEND, INT_MIN,       32'sd0,        9'd0,   1'b0, 32'sd0},
    '{CMD_APPEND, INT_MAX,       32'sd0,        9'd0,   1'b0, 32'sd0},
    '{CMD_APPEND, 32'sd0,        32'sd0,        9'd0,   1'b0, 32'sd0},
    '{CMD_APPEND, -32'sd7,       32'sd0,        9'd0,   1'b0, 32'sd0},
    '{CMD_APPEND, 32'sd100,      32'sd0,        9'd0,   1'b0, 32'sd0},
    '{CMD_APPEND, 32'sd100,      32'sd0,        9'd0,   1'b0, 32'sd0},
    // rank zero or one below the count gives back the bound
    '{CMD_DOWN,   32'sd0,        32'sd42,       9'd0,   1'b1, 32'sd42},
    '{CMD_UP,     32'sd0,        -32'sd9,       9'd1,   1'b1, -32'sd9},
    // rank at or past the count: plain min / max
    '{CMD_DOWN,   32'sd0,        32'sd0,        9'd6,   1'b1, INT_MIN},
    '{CMD_UP,     32'sd0,        32'sd0,        9'd256, 1'b1, INT_MAX},
    // nothing strictly beyond the bound
    '{CMD_DOWN,   32'sd0,        INT_MIN,       9'd2,   1'b1, INT_MIN},
    '{CMD_UP,     32'sd0,        INT_MAX,       9'd2,   1'b1, INT_MAX},
    // real walks, duplicates included
    '{CMD_DOWN,   32'sd0,        INT_MAX,       9'd2,   1'b0, 32'sd0},
    '{CMD_UP,     32'sd0,        INT_MIN,       9'd3,   1'b0, 32'sd0},
    '{CMD_DOWN,   32'sd0,        32'sd101,      9'd5,   1'b0, 32'sd0},
    '{CMD_UP,     32'sd0,        -32'sd8,       9'd5,   1'b0, 32'sd0},
    '{CMD_DOWN,   32'sd0,        32'sd100,      9'd5,   1'b0, 32'sd0},
    '{CMD_CLEAR,  32'sd0,        32'sd0,        9'd0,   1'b0, 32'sd0},
    '{CMD_UP,     32'sd0,        32'sd9,        9'd1,   1'b1, INT_MIN},
    '{CMD_APPEND, 32'sh55555555, 32'sd0,        9'd0,   1'b0, 32'sd0},
    '{CMD_APPEND, 32'shAAAAAAAA, 32'sd0,        9'd0,   1'b0, 32'sd0},
    '{CMD_UP,     32'sd0,        32'sd0,        9'd1,   1'b1, 32'sd0},
    '{CMD_DOWN,   32'sd0,        32'sh60000000, 9'd2,   1'b0, 32'sd0}
  };

  // Handshake mix per phase: none, sender idle, receiver stall, both light.
  localparam int IDLE_MIX [N_PHASES]  = '{0, 62, 0, 12};
  localparam int STALL_MIX [N_PHASES] = '{0, 0, 62, 12};

  logic clk;
  logic rst_n;

  brs_in_if  in_ch_if ();
  brs_out_if out_ch_if ();

  bounded_rank_select_top #(
    .DEPTH(STORE_DEPTH)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch_if),
    .out_ch(out_ch_if)
  );

  // Shadow of the block's store.
  logic signed [DATA_W-1:0] stored_vals [STORE_DEPTH];
  int unsigned              stored_count;

  // Answers owed by the block, oldest first.
  logic signed [DATA_W-1:0] pending_answers [$];
  logic signed [DATA_W-1:0] expected_answer;

  int idle_pct;
  int stall_pct;
  int fail_count;
  int items_taken;   // accepted items that changed state or owe an answer

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Walk from the bound through stored values, one step per rank above one.
  // A rank at or past the count collapses to a single min (down) / max (up)
  // sweep; an empty store therefore returns the sweep seed.
  function automatic logic signed [DATA_W-1:0] select_answer(
    input cmd_t                     cmd,
    input logic signed [DATA_W-1:0] bound,
    input logic [RANK_W-1:0]        rank
  );
    logic signed [DATA_W-1:0] cur;
    logic signed [DATA_W-1:0] best;
    logic                     downward;
    downward = (cmd == CMD_DOWN);
    if (rank >= stored_count) begin
      cur = downward ? INT_MAX : INT_MIN;
      for (int j = 0; j < stored_count; j++) begin
        if (downward ? (stored_vals[j] < cur) : (stored_vals[j] > cur)) begin
          cur = stored_vals[j];
        end
      end
      return cur;
    end
    cur = bound;
    for (int i = 1; i < rank; i++) begin
      // nothing beyond the bound leaves the opposite extreme
      best = downward ? INT_MIN : INT_MAX;
      for (int j = 0; j < stored_count; j++) begin
        if (downward) begin
          if (stored_vals[j] > best && stored_vals[j] < cur) best = stored_vals[j];
        end else begin
          if (stored_vals[j] < best && stored_vals[j] > cur) best = stored_vals[j];
        end
      end
      cur = best;
    end
    return cur;
  endfunction

  // Drive one item, hold it until taken, then update the shadow store and
  // queue the answer it owes. Items go out in order, so predicting at
  // acceptance sees exactly the state the block will see.
  task automatic send_item(
    input cmd_t                     cmd,
    input logic signed [DATA_W-1:0] value,
    input logic signed [DATA_W-1:0] bound,
    input logic [RANK_W-1:0]        rank,
    input logic                     has_answer,
    input logic signed [DATA_W-1:0] answer
  );
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch_if.valid <= 1'b1;
    in_ch_if.cmd   <= cmd;
    in_ch_if.value <= value;
    in_ch_if.bound <= bound;
    in_ch_if.rank  <= rank;
    do @(posedge clk); while (!in_ch_if.ready);

    case (cmd)
      CMD_CLEAR: begin
        stored_count = 0;
        items_taken++;
      end
      CMD_APPEND: begin
        // append to a full store is dropped by the block
        if (stored_count < STORE_DEPTH) begin
          stored_vals[stored_count] = value;
          stored_count++;
          items_taken++;
        end
      end
      default: begin
        pending_answers.push_back(has_answer ? answer : select_answer(cmd, bound, rank));
        items_taken++;
      end
    endcase
  endtask

  // Extremes, small values for duplicates, otherwise anything.
  function automatic logic signed [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return INT_MIN;
      1:       return INT_MAX;
      2, 3, 4: return $signed($urandom_range(0, 16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  // Bounds near stored values hit the strict-compare edges.
  function automatic logic signed [DATA_W-1:0] rand_bound();
    if (stored_count > 0 && $urandom_range(0, 1) == 1) begin
      return stored_vals[$urandom_range(0, stored_count - 1)]
             + $signed($urandom_range(0, 2)) - 1;
    end
    return rand_word();
  endfunction

  // Mostly ranks around the count so real walks happen; now and then rank
  // 256, the store depth, or any rank up to it.
  function automatic logic [RANK_W-1:0] rand_rank();
    case ($urandom_range(0, 7))
      0:       return 9'd256;
      1:       return RANK_W'($urandom_range(0, 256));
      default: return RANK_W'($urandom_range(0, stored_count + 1));
    endcase
  endfunction

  function automatic cmd_t rand_query();
    return $urandom_range(0, 1) ? CMD_UP : CMD_DOWN;
  endfunction

  // One well-formed sequence: usually a clear, some appends, then queries
  // with the odd append mixed in. Unused fields carry noise. Stores stay
  // small so query walks remain short.
  task automatic run_episode();
    int n_vals;
    int n_queries;
    if (stored_count > 16 || $urandom_range(0, 3) != 0) begin
      send_item(CMD_CLEAR, $urandom, $urandom, RANK_W'($urandom), 1'b0, '0);
    end
    n_vals = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
    repeat (n_vals) send_item(CMD_APPEND, rand_word(), $urandom, RANK_W'($urandom), 1'b0, '0);
    n_queries = $urandom_range(1, 5);
    repeat (n_queries) begin
      if ($urandom_range(0, 4) == 0) begin
        send_item(CMD_APPEND, rand_word(), $urandom, RANK_W'($urandom), 1'b0, '0);
      end
      send_item(rand_query(), $urandom, rand_bound(), rand_rank(), 1'b0, '0);
    end
  endtask

  // Receiver: check every answer taken, then pick next cycle's ready.
  always @(posedge clk) begin
    if (rst_n && out_ch_if.valid && out_ch_if.ready) begin
      if (pending_answers.size() == 0) begin
        $error("answer: expected none, got %0d", out_ch_if.answer);
        fail_count++;
      end else begin
        expected_answer = pending_answers.pop_front();
        if (out_ch_if.answer !== expected_answer) begin
          $error("answer: expected %0d, got %0d", expected_answer, out_ch_if.answer);
          fail_count++;
        end
      end
    end
    out_ch_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin
    int phase_start;
    fail_count   = 0;
    items_taken  = 0;
    stored_count = 0;
    idle_pct     = 0;
    stall_pct    = 0;

    rst_n           <= 1'b0;
    in_ch_if.valid  <= 1'b0;
    in_ch_if.cmd    <= CMD_CLEAR;
    in_ch_if.value  <= '0;
    in_ch_if.bound  <= '0;
    in_ch_if.rank   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, no idling
    for (int r = 0; r < N_ROWS; r++) begin
      send_item(DIRECTED[r].cmd, DIRECTED[r].value, DIRECTED[r].bound,
                DIRECTED[r].rank, DIRECTED[r].has_answer, DIRECTED[r].answer);
    end

    // random sequences under each handshake mix
    for (int p = 0; p < N_PHASES; p++) begin
      idle_pct    = IDLE_MIX[p];
      stall_pct   = STALL_MIX[p];
      phase_start = items_taken;
      while (items_taken - phase_start < PHASE_ITEMS) run_episode();
    end

    in_ch_if.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    // catch anything stray after the last answer
    repeat (20) @(posedge clk);

    if (fail_count == 0) begin
      $display("[bounded_rank_select_top] OK");
    end else begin
      $display("[bounded_rank_select_top] ERROR");
    end
    $finish;
  end

  // Stores hold at most 33 values, so query walks stay short; this timeout
  // only catches a hung run.
  initial begin
    #20_000_000;
    $display("[bounded_rank_select_top] ERROR");
    $finish;
  end

endmodule
